// ===== rtl/core/ivcr_pkg.sv =====
package ivcr_pkg;

  // Kernel capacity and derived widths
  localparam int MAX_KERNEL = 256;
  localparam int TAP_W      = $clog2(MAX_KERNEL);
  localparam int CNT_W      = TAP_W + 1;

  // Fixed field widths
  localparam int KLEN_W   = 9;
  localparam int SLEN_W   = 16;
  localparam int DIV_W    = 31;
  localparam int DATA_W   = 32;
  localparam int SAMPLE_W = 8;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int CFG_IDX_W = 3;

  // Bit-serial divider: one quotient bit per cycle
  localparam int DIV_STEPS = DATA_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Saturation bounds of the requantized output
  localparam logic signed [DATA_W-1:0] CLIP_MAX = 32'sd127;
  localparam logic signed [DATA_W-1:0] CLIP_MIN = -32'sd128;

  // Request command codes
  localparam logic CMD_KERNEL = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_LEN   = 3'd0,
    REG_SIGNAL_LEN   = 3'd1,
    REG_SCALE_ENABLE = 3'd2,
    REG_DIVISOR      = 3'd3,
    REG_OFFSET       = 3'd4
  } reg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             kern_wr;
    logic [TAP_W-1:0] kern_addr;
    logic             win_wr;
    logic             tap_rd;
    logic [TAP_W-1:0] tap;
    logic             acc_clr;
    logic             div_start;
    logic             div_step;
    logic             out_load;
    logic             last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/ivcr_ram.sv =====
module ivcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ivcr_datapath.sv =====
module ivcr_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ivcr_pkg::dp_cmd_t                    cmd_i,
  output ivcr_pkg::dp_status_t                 status_o,
  input  logic signed [ivcr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 scale_en_i,
  input  logic [ivcr_pkg::DIV_W-1:0]           div_i,
  input  logic [ivcr_pkg::DATA_W-1:0]          offset_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [ivcr_pkg::DATA_W-1:0]   result_value_o,
  output logic                                 result_last_o
);

  logic [ivcr_pkg::TAP_W-1:0]    wp_q, wp_d;
  logic [ivcr_pkg::TAP_W-1:0]    win_raddr;
  logic [ivcr_pkg::SAMPLE_W-1:0] kern_rdata, win_rdata;
  logic                          v1_q, v2_q;
  logic signed [ivcr_pkg::PROD_W-1:0] prod_q;
  logic [ivcr_pkg::DATA_W-1:0]   acc_q, acc_d;
  logic [ivcr_pkg::DATA_W-1:0]   biased;
  logic [ivcr_pkg::DATA_W-1:0]   quo_q, quo_d;
  logic [ivcr_pkg::DIV_W-1:0]    rem_q, rem_d;
  logic                          neg_q, neg_d;
  logic [ivcr_pkg::DATA_W-1:0]   trial, diff;
  logic                          ge;
  logic [ivcr_pkg::DATA_W-1:0]   clipped;
  logic                          out_valid_q, out_valid_d;
  logic [ivcr_pkg::DATA_W-1:0]   out_value_q, out_value_d;
  logic                          out_last_q;

  // Kernel storage, addressed by tap index
  ivcr_ram #(
    .WIDTH (ivcr_pkg::SAMPLE_W),
    .DEPTH (ivcr_pkg::MAX_KERNEL)
  ) u_kern_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.kern_wr),
    .waddr_i (cmd_i.kern_addr),
    .wdata_i (sample_i),
    .raddr_i (cmd_i.tap),
    .rdata_o (kern_rdata)
  );

  // Signal history as a circular buffer; tap 0 is the newest sample
  assign win_raddr = wp_q - ivcr_pkg::TAP_W'(1) - cmd_i.tap;

  ivcr_ram #(
    .WIDTH (ivcr_pkg::SAMPLE_W),
    .DEPTH (ivcr_pkg::MAX_KERNEL)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.win_wr),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  assign wp_d = cmd_i.win_wr ? wp_q + ivcr_pkg::TAP_W'(1) : wp_q;

  // Accumulate: product register, then 32-bit wrapping add
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = acc_q + ivcr_pkg::DATA_W'(prod_q);
    end
  end

  // Restoring divider on the magnitude, one bit per step
  assign biased = acc_q + offset_i;
  assign trial  = {rem_q, quo_q[ivcr_pkg::DATA_W-1]};
  assign diff   = trial - {1'b0, div_i};
  assign ge     = trial >= {1'b0, div_i};

  always_comb begin
    neg_d = neg_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_start) begin
      neg_d = biased[ivcr_pkg::DATA_W-1];
      rem_d = '0;
      quo_d = biased[ivcr_pkg::DATA_W-1] ? (~biased + 1'b1) : biased;
    end else if (cmd_i.div_step) begin
      rem_d = ge ? diff[ivcr_pkg::DIV_W-1:0] : trial[ivcr_pkg::DIV_W-1:0];
      quo_d = {quo_q[ivcr_pkg::DATA_W-2:0], ge};
    end
  end

  // Sign and saturate the quotient
  always_comb begin
    if (neg_q) begin
      clipped = (quo_q > ivcr_pkg::DATA_W'(-ivcr_pkg::CLIP_MIN)) ?
                ivcr_pkg::CLIP_MIN : (~quo_q + 1'b1);
    end else begin
      clipped = (quo_q > ivcr_pkg::DATA_W'(ivcr_pkg::CLIP_MAX)) ?
                ivcr_pkg::CLIP_MAX : quo_q;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_value_d = scale_en_i ? clipped : acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      v1_q        <= cmd_i.tap_rd;
      v2_q        <= v1_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= $signed(win_rdata) * $signed(kern_rdata);
    acc_q       <= acc_d;
    neg_q       <= neg_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    out_value_q <= out_value_d;
    if (cmd_i.out_load) begin
      out_last_q <= cmd_i.last;
    end
  end

  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign result_last_o  = out_last_q;

endmodule

// ===== rtl/core/ivcr_ctrl.sv =====
module ivcr_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [ivcr_pkg::CNT_W-1:0]   k_eff_i,
  input  logic [ivcr_pkg::SLEN_W-1:0]  len_eff_i,
  input  logic                         scale_en_i,
  input  ivcr_pkg::dp_status_t         status_i,
  output ivcr_pkg::dp_cmd_t            dp_cmd_o
);

  ivcr_pkg::state_e state_q, state_d;

  logic [ivcr_pkg::CNT_W-1:0]  kcnt_q, kcnt_d, kbase;
  logic [ivcr_pkg::SLEN_W-1:0] scnt_q, scnt_d, scnt_inc;
  logic [ivcr_pkg::TAP_W-1:0]  idx_q, idx_d;
  logic [ivcr_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
  logic                        last_q, last_d;
  logic                        accept;
  logic                        is_last, emit, tap_end, div_end;

  // Request decode
  assign accept   = (state_q == ivcr_pkg::ST_IDLE) && in_valid_i;
  assign kbase    = (kcnt_q >= k_eff_i) ? '0 : kcnt_q;
  assign scnt_inc = scnt_q + ivcr_pkg::SLEN_W'(1);
  assign is_last  = scnt_inc >= len_eff_i;
  assign emit     = scnt_inc >= ivcr_pkg::SLEN_W'(k_eff_i);
  assign tap_end  = {1'b0, idx_q} == (k_eff_i - ivcr_pkg::CNT_W'(1));
  assign div_end  = dcnt_q == ivcr_pkg::DCNT_W'(ivcr_pkg::DIV_STEPS - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ivcr_pkg::ST_IDLE: begin
        if (accept && cmd_i == ivcr_pkg::CMD_SAMPLE && emit) begin
          state_d = ivcr_pkg::ST_MAC;
        end
      end
      ivcr_pkg::ST_MAC: begin
        if (tap_end) begin
          state_d = ivcr_pkg::ST_DRAIN;
        end
      end
      ivcr_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = scale_en_i ? ivcr_pkg::ST_DIV : ivcr_pkg::ST_DONE;
        end
      end
      ivcr_pkg::ST_DIV: begin
        if (div_end) begin
          state_d = ivcr_pkg::ST_DONE;
        end
      end
      ivcr_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ivcr_pkg::ST_IDLE;
        end
      end
      default: state_d = ivcr_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    in_ready_o = 1'b0;
    dp_cmd_o   = '0;
    dp_cmd_o.kern_addr = kbase[ivcr_pkg::TAP_W-1:0];
    dp_cmd_o.tap       = idx_q;
    dp_cmd_o.last      = last_q;
    unique case (state_q)
      ivcr_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        dp_cmd_o.kern_wr = accept && cmd_i == ivcr_pkg::CMD_KERNEL;
        dp_cmd_o.win_wr  = accept && cmd_i == ivcr_pkg::CMD_SAMPLE;
        dp_cmd_o.acc_clr = 1'b1;
      end
      ivcr_pkg::ST_MAC: begin
        dp_cmd_o.tap_rd = 1'b1;
      end
      ivcr_pkg::ST_DRAIN: begin
        dp_cmd_o.div_start = !status_i.pipe_busy && scale_en_i;
      end
      ivcr_pkg::ST_DIV: begin
        dp_cmd_o.div_step = 1'b1;
      end
      ivcr_pkg::ST_DONE: begin
        dp_cmd_o.out_load = status_i.out_free;
      end
      default: ;
    endcase
  end

  // Kernel, sample, tap and divider counters
  always_comb begin
    kcnt_d = kcnt_q;
    scnt_d = scnt_q;
    last_d = last_q;
    idx_d  = idx_q;
    dcnt_d = dcnt_q;
    if (accept) begin
      if (cmd_i == ivcr_pkg::CMD_KERNEL) begin
        kcnt_d = kbase + ivcr_pkg::CNT_W'(1);
        scnt_d = '0;
      end else begin
        scnt_d = is_last ? '0 : scnt_inc;
        last_d = is_last;
      end
    end
    if (state_q == ivcr_pkg::ST_IDLE) begin
      idx_d = '0;
    end else if (state_q == ivcr_pkg::ST_MAC) begin
      idx_d = idx_q + ivcr_pkg::TAP_W'(1);
    end
    if (state_q == ivcr_pkg::ST_DIV) begin
      dcnt_d = dcnt_q + ivcr_pkg::DCNT_W'(1);
    end else begin
      dcnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ivcr_pkg::ST_IDLE;
      kcnt_q  <= '0;
      scnt_q  <= '0;
      last_q  <= 1'b0;
      idx_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      kcnt_q  <= kcnt_d;
      scnt_q  <= scnt_d;
      last_q  <= last_d;
      idx_q   <= idx_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // A tap read never runs past the kernel length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.tap_rd |-> ({1'b0, idx_q} < k_eff_i))
    else $error("tap read beyond kernel length");

  // MAC work starts only from an accepted signal sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ivcr_pkg::ST_IDLE && state_d == ivcr_pkg::ST_MAC)
      |-> (in_valid_i && cmd_i == ivcr_pkg::CMD_SAMPLE))
    else $error("MAC started without a sample request");

  // Division runs only in scale mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ivcr_pkg::ST_DIV |-> scale_en_i)
    else $error("divider active in raw mode");

  // A loaded result returns the controller to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.out_load |=> state_q == ivcr_pkg::ST_IDLE)
    else $error("controller did not return to idle after result");

endmodule

// ===== rtl/core/int8_valid_convolution_requant.sv =====
// Valid-region 1-D convolution of signed 8-bit vectors with optional
// requantization. Load the kernel first (cmd 0, one element per request,
// up to 256 taps), then stream the signal (cmd 1). Once kernel_len samples
// of the current vector are held, each sample yields one result: the
// 32-bit wrapping sum of the last kernel_len samples times the kernel, or,
// with scale_enable set, (sum + offset) divided by the divisor register,
// truncated toward zero and clipped to [-128, 127]. result_last marks the
// final result of a vector. Kernel loads and samples that give no result
// leave the block idle. A sample that gives a result runs through the
// taps and, in scale mode, the divider: one shared multiply-accumulate
// reads one tap per cycle from the kernel and history RAMs, and the
// divider retires one quotient bit per cycle. A finished result waits in
// the output register while the next request is taken. Registers are
// to be written by the user through the configuration port only while
// the block is idle; the block itself does not enforce it. kernel_len 0
// acts as 1, above 256 as 256, signal_len 0 as 1 and a zero divisor as 1.
module int8_valid_convolution_requant (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ivcr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ivcr_pkg::DATA_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic signed [ivcr_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ivcr_pkg::DATA_W-1:0]   result_value_o,
  output logic                                 result_last_o
);

  logic [ivcr_pkg::KLEN_W-1:0] kernel_len_q;
  logic [ivcr_pkg::SLEN_W-1:0] signal_len_q;
  logic                        scale_enable_q;
  logic [ivcr_pkg::DIV_W-1:0]  divisor_q;
  logic [ivcr_pkg::DATA_W-1:0] offset_q;

  logic [ivcr_pkg::CNT_W-1:0]  k_eff;
  logic [ivcr_pkg::SLEN_W-1:0] len_eff;
  logic [ivcr_pkg::DIV_W-1:0]  div_eff;

  ivcr_pkg::dp_cmd_t    dp_cmd;
  ivcr_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_len_q   <= ivcr_pkg::KLEN_W'(1);
      signal_len_q   <= ivcr_pkg::SLEN_W'(1);
      scale_enable_q <= 1'b0;
      divisor_q      <= ivcr_pkg::DIV_W'(1);
      offset_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (ivcr_pkg::reg_idx_e'(cfg_index_i))
        ivcr_pkg::REG_KERNEL_LEN:   kernel_len_q   <= cfg_data_i[ivcr_pkg::KLEN_W-1:0];
        ivcr_pkg::REG_SIGNAL_LEN:   signal_len_q   <= cfg_data_i[ivcr_pkg::SLEN_W-1:0];
        ivcr_pkg::REG_SCALE_ENABLE: scale_enable_q <= cfg_data_i[0];
        ivcr_pkg::REG_DIVISOR:      divisor_q      <= cfg_data_i[ivcr_pkg::DIV_W-1:0];
        ivcr_pkg::REG_OFFSET:       offset_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective lengths and divisor
  always_comb begin
    if (kernel_len_q == '0) begin
      k_eff = ivcr_pkg::CNT_W'(1);
    end else if (32'(kernel_len_q) > 32'(ivcr_pkg::MAX_KERNEL)) begin
      k_eff = ivcr_pkg::CNT_W'(ivcr_pkg::MAX_KERNEL);
    end else begin
      k_eff = ivcr_pkg::CNT_W'(kernel_len_q);
    end
  end

  assign len_eff = (signal_len_q == '0) ? ivcr_pkg::SLEN_W'(1) : signal_len_q;
  assign div_eff = (divisor_q == '0) ? ivcr_pkg::DIV_W'(1) : divisor_q;

  ivcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .k_eff_i    (k_eff),
    .len_eff_i  (len_eff),
    .scale_en_i (scale_enable_q),
    .status_i   (dp_status),
    .dp_cmd_o   (dp_cmd)
  );

  ivcr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .sample_i       (sample_i),
    .scale_en_i     (scale_enable_q),
    .div_i          (div_eff),
    .offset_i       (offset_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .result_value_o (result_value_o),
    .result_last_o  (result_last_o)
  );

endmodule
